@@ sv/ppre_pkg.sv @@
// Shared types, widths and constants for the planar point repulsion energy block.
// No dependencies; ppre_ctrl, ppre_dp and the top level refer to this package by scoped names.
package ppre_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CW         = 24;   // coordinate width, Q4.20
    localparam int EW         = 40;   // energy width, Q20.20
    localparam int ACC_W      = 48;
    localparam int SQ_W       = 50;   // squared distance
    localparam int RT_W       = 25;   // square root
    localparam int NUM_W      = 38;   // pair numerator

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_MOVE  = 2'd2;

    localparam logic [SQ_W-1:0]  MIN_R2  = 50'd109951163;
    localparam logic [SQ_W-1:0]  WALL_R2 = 50'd1099511627776;
    localparam logic [NUM_W-1:0] PAIR_K  = 38'd109951162778;
    localparam logic [ACC_W-1:0] E_MAX   = 48'd1099511627775;

    typedef struct packed {
        logic [1:0]           req_type;
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] step;
    } t_req;

    typedef struct packed {
        logic [EW-1:0] energy;
        logic          saturated;
    } t_res;

    typedef struct packed {
        logic [IDX_W-1:0] addr;
        logic             load_we;
        logic             begin_move;
        logic             mv_mul;
        logic             mv_wr;
        logic             ld_i;
        logic             sq_pair;
        logic             sq_wall;
        logic             sqrt_pair;
        logic             sqrt_wall;
        logic             div_start;
        logic             acc_pair;
        logic             wl_mul;
        logic             wl_acc;
    } t_cmd;

    typedef struct packed {
        logic sq_busy;
        logic div_busy;
        logic wall_out;
    } t_sts;

endpackage

@@ sv/ppre_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module ppre_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ sv/ppre_ctrl.sv @@
// Controller: sequences clear, load and the move / pair / wall passes.
// Depends on ppre_pkg; drives the datapath through t_cmd, reads t_sts.
module ppre_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_req_type,
    input  ppre_pkg::t_sts    i_sts,
    output logic              o_busy,
    output logic              o_res_valid,
    output ppre_pkg::t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MV_RD  = 4'd1;
    localparam logic [3:0] S_MV_MUL = 4'd2;
    localparam logic [3:0] S_MV_WR  = 4'd3;
    localparam logic [3:0] S_PI_RD  = 4'd4;
    localparam logic [3:0] S_PI_LD  = 4'd5;
    localparam logic [3:0] S_PJ_RD  = 4'd6;
    localparam logic [3:0] S_PJ_LD  = 4'd7;
    localparam logic [3:0] S_PJ_R2  = 4'd8;
    localparam logic [3:0] S_PJ_SQ  = 4'd9;
    localparam logic [3:0] S_PJ_DIV = 4'd10;
    localparam logic [3:0] S_WL_SQR = 4'd11;
    localparam logic [3:0] S_WL_CHK = 4'd12;
    localparam logic [3:0] S_WL_SQ  = 4'd13;
    localparam logic [3:0] S_WL_ACC = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0]                 r_state, n_state;
    logic [ppre_pkg::CNT_W-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j;
    logic [ppre_pkg::CNT_W-1:0] i_inc, j_inc;
    ppre_pkg::t_cmd             cmd;

    assign i_inc = r_i + 1'b1;
    assign j_inc = r_j + 1'b1;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_req_type)
                        ppre_pkg::REQ_CLEAR: n_cnt = '0;
                        ppre_pkg::REQ_LOAD: begin
                            if (r_cnt < ppre_pkg::CNT_W'(ppre_pkg::MAX_POINTS)) begin
                                cmd.addr    = r_cnt[ppre_pkg::IDX_W-1:0];
                                cmd.load_we = 1'b1;
                                n_cnt       = r_cnt + 1'b1;
                            end
                        end
                        ppre_pkg::REQ_MOVE: begin
                            cmd.begin_move = 1'b1;
                            n_i            = '0;
                            n_state        = (r_cnt == '0) ? S_DONE : S_MV_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_MV_RD: begin
                cmd.addr = r_i[ppre_pkg::IDX_W-1:0];
                n_state  = S_MV_MUL;
            end
            S_MV_MUL: begin
                cmd.addr   = r_i[ppre_pkg::IDX_W-1:0];
                cmd.mv_mul = 1'b1;
                n_state    = S_MV_WR;
            end
            S_MV_WR: begin
                cmd.addr  = r_i[ppre_pkg::IDX_W-1:0];
                cmd.mv_wr = 1'b1;
                if (i_inc == r_cnt) begin
                    n_i     = '0;
                    n_state = S_PI_RD;
                end else begin
                    n_i     = i_inc;
                    n_state = S_MV_RD;
                end
            end
            S_PI_RD: begin
                cmd.addr = r_i[ppre_pkg::IDX_W-1:0];
                n_state  = S_PI_LD;
            end
            S_PI_LD: begin
                cmd.ld_i = 1'b1;
                n_j      = '0;
                n_state  = (r_i == '0) ? S_WL_SQR : S_PJ_RD;
            end
            S_PJ_RD: begin
                cmd.addr = r_j[ppre_pkg::IDX_W-1:0];
                n_state  = S_PJ_LD;
            end
            S_PJ_LD: begin
                cmd.sq_pair = 1'b1;
                n_state     = S_PJ_R2;
            end
            S_PJ_R2: begin
                cmd.sqrt_pair = 1'b1;
                n_state       = S_PJ_SQ;
            end
            S_PJ_SQ: begin
                if (!i_sts.sq_busy) begin
                    cmd.div_start = 1'b1;
                    n_state       = S_PJ_DIV;
                end
            end
            S_PJ_DIV: begin
                if (!i_sts.div_busy) begin
                    cmd.acc_pair = 1'b1;
                    if (j_inc == r_i) begin
                        n_state = S_WL_SQR;
                    end else begin
                        n_j     = j_inc;
                        n_state = S_PJ_RD;
                    end
                end
            end
            S_WL_SQR: begin
                cmd.sq_wall = 1'b1;
                n_state     = S_WL_CHK;
            end
            S_WL_CHK: begin
                if (i_sts.wall_out) begin
                    cmd.sqrt_wall = 1'b1;
                    n_state       = S_WL_SQ;
                end else if (i_inc == r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = i_inc;
                    n_state = S_PI_RD;
                end
            end
            S_WL_SQ: begin
                if (!i_sts.sq_busy) begin
                    cmd.wl_mul = 1'b1;
                    n_state    = S_WL_ACC;
                end
            end
            S_WL_ACC: begin
                cmd.wl_acc = 1'b1;
                if (i_inc == r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = i_inc;
                    n_state = S_PI_RD;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_cmd       = cmd;
endmodule

@@ sv/ppre_dp.sv @@
// Datapath: point stores, move arithmetic, a square-root unit shared by pair and wall terms,
// a divide unit, energy accumulator. Depends on ppre_pkg and ppre_ram.
module ppre_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppre_pkg::t_req i_req,
    input  ppre_pkg::t_cmd i_cmd,
    output ppre_pkg::t_sts o_sts,
    output ppre_pkg::t_res o_res
);
    localparam int CW = ppre_pkg::CW;

    // point stores: {y, x} positions and {y, x} forces
    logic [2*CW-1:0] pos_wd, pos_rd, frc_rd;
    logic            pos_we;

    logic signed [CW-1:0]     r_step, r_cx, r_cy, r_xi, r_yi, nx, ny;
    logic signed [2*CW-1:0]   r_px, r_py;
    logic                     r_sat, sat_x, sat_y;
    logic [ppre_pkg::ACC_W-1:0] r_acc;

    logic signed [CW:0]       opa, opb;
    logic signed [2*CW+1:0]   prod_a, prod_b;
    logic [ppre_pkg::SQ_W-1:0] r_sqa, r_sqb, r2, r2_pair;

    // square-root unit
    logic [ppre_pkg::SQ_W-1:0] r_sv;
    logic [ppre_pkg::RT_W:0]   r_srem;
    logic [ppre_pkg::RT_W-1:0] r_root;
    logic [4:0]                r_scnt;
    logic                      r_sbusy;
    logic [ppre_pkg::RT_W+2:0] srem2, strial;

    // divide unit
    logic [ppre_pkg::NUM_W-1:0] r_num;
    logic [ppre_pkg::RT_W-1:0]  r_dvs, r_drem;
    logic [ppre_pkg::RT_W:0]    drem2;
    logic [5:0]                 r_dcnt;
    logic                       r_dbusy;

    // wall term
    logic [CW-1:0]    wd;
    logic [2*CW-1:0]  r_dd;
    logic [55:0]      wterm;

    function automatic logic signed [CW:0] move_c(input logic signed [CW-1:0] c,
                                                  input logic signed [2*CW-1:0] p);
        logic signed [2*CW:0] rp;
        logic signed [2*CW:0] sh;
        logic signed [CW+5:0] s;
        rp = {p[2*CW-1], p} + 49'sd524288;
        sh = rp >>> 20;
        s  = {{6{c[CW-1]}}, c} + sh[CW+5:0];
        if (s > 30'sd8388607) begin
            move_c = {1'b1, 24'sh7FFFFF};
        end else if (s < -30'sd8388608) begin
            move_c = {1'b1, 24'sh800000};
        end else begin
            move_c = {1'b0, s[CW-1:0]};
        end
    endfunction

    assign {sat_x, nx} = move_c(r_cx, r_px);
    assign {sat_y, ny} = move_c(r_cy, r_py);

    assign pos_we = i_cmd.load_we | i_cmd.mv_wr;
    assign pos_wd = i_cmd.load_we ? {i_req.pos_y, i_req.pos_x} : {ny, nx};

    ppre_ram #(.W(2*CW), .D(ppre_pkg::MAX_POINTS)) u_pos (
        .i_clk  (i_clk),
        .i_we   (pos_we),
        .i_addr (i_cmd.addr),
        .i_wdata(pos_wd),
        .o_rdata(pos_rd)
    );

    ppre_ram #(.W(2*CW), .D(ppre_pkg::MAX_POINTS)) u_frc (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load_we),
        .i_addr (i_cmd.addr),
        .i_wdata({i_req.dir_y, i_req.dir_x}),
        .o_rdata(frc_rd)
    );

    // squaring operands: pair differences or the point itself for the wall
    always_comb begin
        if (i_cmd.sq_pair) begin
            opa = {pos_rd[CW-1], pos_rd[CW-1:0]} - {r_xi[CW-1], r_xi};
            opb = {pos_rd[2*CW-1], pos_rd[2*CW-1:CW]} - {r_yi[CW-1], r_yi};
        end else begin
            opa = {r_xi[CW-1], r_xi};
            opb = {r_yi[CW-1], r_yi};
        end
    end
    assign prod_a  = opa * opa;
    assign prod_b  = opb * opb;
    assign r2      = r_sqa + r_sqb;
    assign r2_pair = (r2 < ppre_pkg::MIN_R2) ? ppre_pkg::MIN_R2 : r2;

    assign strial = {1'b0, r_root, 2'b01};
    assign srem2  = {r_srem, r_sv[ppre_pkg::SQ_W-1 -: 2]};
    assign drem2  = {r_drem, r_num[ppre_pkg::NUM_W-1]};

    assign wd    = r_root[CW-1:0] - 24'd1048576;
    assign wterm = 56'(r_dd) * 56'd100 + 56'd524288;

    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_move) begin
            r_step <= i_req.step;
        end
        if (i_cmd.mv_mul) begin
            r_cx <= pos_rd[CW-1:0];
            r_cy <= pos_rd[2*CW-1:CW];
            r_px <= r_step * $signed(frc_rd[CW-1:0]);
            r_py <= r_step * $signed(frc_rd[2*CW-1:CW]);
        end
        if (i_cmd.ld_i) begin
            r_xi <= pos_rd[CW-1:0];
            r_yi <= pos_rd[2*CW-1:CW];
        end
        if (i_cmd.sq_pair || i_cmd.sq_wall) begin
            r_sqa <= prod_a[ppre_pkg::SQ_W-1:0];
            r_sqb <= prod_b[ppre_pkg::SQ_W-1:0];
        end
        if (i_cmd.wl_mul) begin
            r_dd <= wd * wd;
        end
        // accumulator and flag
        if (i_cmd.begin_move) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else begin
            if (i_cmd.mv_wr) begin
                r_sat <= r_sat | sat_x | sat_y;
            end
            if (i_cmd.acc_pair) begin
                r_acc <= r_acc + ppre_pkg::ACC_W'(r_num);
            end else if (i_cmd.wl_acc) begin
                r_acc <= r_acc + ppre_pkg::ACC_W'(wterm[55:20]);
            end
        end
    end

    // square root: two radicand bits a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
        end else if (i_cmd.sqrt_pair || i_cmd.sqrt_wall) begin
            r_sbusy <= 1'b1;
        end else if (r_sbusy && r_scnt == '0) begin
            r_sbusy <= 1'b0;
        end
        if (i_cmd.sqrt_pair || i_cmd.sqrt_wall) begin
            r_sv   <= i_cmd.sqrt_pair ? r2_pair : r2;
            r_srem <= '0;
            r_root <= '0;
            r_scnt <= 5'd24;
        end else if (r_sbusy) begin
            r_sv   <= {r_sv[ppre_pkg::SQ_W-3:0], 2'b00};
            r_scnt <= r_scnt - 1'b1;
            if (srem2 >= strial) begin
                r_srem <= (ppre_pkg::RT_W+1)'(srem2 - strial);
                r_root <= {r_root[ppre_pkg::RT_W-2:0], 1'b1};
            end else begin
                r_srem <= srem2[ppre_pkg::RT_W:0];
                r_root <= {r_root[ppre_pkg::RT_W-2:0], 1'b0};
            end
        end
    end

    // restoring divide, one quotient bit a cycle; quotient shifts into r_num
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
        end else if (r_dbusy && r_dcnt == '0) begin
            r_dbusy <= 1'b0;
        end
        if (i_cmd.div_start) begin
            r_num  <= ppre_pkg::PAIR_K + ppre_pkg::NUM_W'(r_root >> 1);
            r_dvs  <= r_root;
            r_drem <= '0;
            r_dcnt <= 6'(ppre_pkg::NUM_W - 1);
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt - 1'b1;
            if (drem2 >= {1'b0, r_dvs}) begin
                r_drem <= ppre_pkg::RT_W'(drem2 - {1'b0, r_dvs});
                r_num  <= {r_num[ppre_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_drem <= drem2[ppre_pkg::RT_W-1:0];
                r_num  <= {r_num[ppre_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.sq_busy  = r_sbusy;
    assign o_sts.div_busy = r_dbusy;
    assign o_sts.wall_out = (r2 > ppre_pkg::WALL_R2);

    assign o_res.energy    = (r_acc > ppre_pkg::E_MAX) ? ppre_pkg::E_MAX[ppre_pkg::EW-1:0]
                                                       : r_acc[ppre_pkg::EW-1:0];
    assign o_res.saturated = r_sat | (r_acc > ppre_pkg::E_MAX);
endmodule

@@ sv/planar_point_repulsion_energy.sv @@
// Top level of the planar point repulsion energy block.
// Depends on ppre_pkg, ppre_ctrl and ppre_dp.
//
//  channel   handshake                     payload
//  request   start in, busy out            i_req  (ppre_pkg::t_req)
//  result    o_res_valid out, one cycle    o_res  (ppre_pkg::t_res)
//
// Clear and load keep busy low. A move transaction keeps busy high while it moves
// every point, then sums the pair terms and a wall term for each moved point
// outside the unit circle; its length is set by the serial square root (25
// iterations) and divide (38 iterations) that every pair passes through. Reset
// is synchronous, active low, and empties the set. The receiver cannot stall:
// the result shows for one cycle.
module planar_point_repulsion_energy (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ppre_pkg::t_req i_req,
    output logic           o_res_valid,
    output ppre_pkg::t_res o_res
);
    ppre_pkg::t_cmd cmd;
    ppre_pkg::t_sts sts;

    ppre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_res_valid(o_res_valid),
        .o_cmd      (cmd)
    );

    ppre_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_res  (o_res)
    );

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid) else $error("result strobe longer than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy) else $error("result outside a move transaction");

    a_no_busy_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type != ppre_pkg::REQ_MOVE) |=> !busy)
        else $error("clear or load left the block busy");

    a_no_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type != ppre_pkg::REQ_MOVE) |=> !o_res_valid)
        else $error("clear or load produced a result");
`endif
endmodule
